### rtl/pcpr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the collinear vertex removal block.
package pcpr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int MIN_RING   = 3;
	localparam int TOL_W      = 32;

	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SEQ_W      = $clog2(MAX_POINTS + 2);
	localparam int BANKS      = 2;
	localparam int BANK_W     = $clog2(BANKS);
	localparam int ADDR_W     = BANK_W + IDX_W;
	localparam int MEM_DEPTH  = 1 << ADDR_W;
	localparam int KEEP_DEPTH = 1 << IDX_W;

	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CSQ_W      = 2 * PROD_W;
	localparam int LHS_W      = CSQ_W + TOL_W;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100000000);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         point_last;
	} point_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic                         out_last;
		logic                         ring_unchanged;
		logic                         overflow;
	} result_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0]  count;
		logic              overflow;
	} ring_desc_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_W-1:0]     addr;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} vtx_wr_t;

endpackage

### rtl/pcpr_front.sv
`timescale 1ns / 1ps
// Front end: accepts vertices, writes them to the current bank and closes rings.
module pcpr_front import pcpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  point_t     in_data,
	input  logic       q_full,
	output vtx_wr_t    wr,
	output logic       push,
	output ring_desc_t push_desc
);

	logic [CNT_W-1:0]  count_q;
	logic              overflow_q;
	logic [BANK_W-1:0] bank_q;
	logic              accept;
	logic              room;

	// Both banks are owned by the back end while the ring queue is full.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign room     = count_q < CNT_W'(MAX_POINTS);
	assign push     = accept && in_data.point_last;

	always_comb begin
		wr.en              = accept && room;
		wr.addr            = {bank_q, count_q[IDX_W-1:0]};
		wr.x               = in_data.point_x;
		wr.y               = in_data.point_y;
		push_desc.bank     = bank_q;
		push_desc.count    = room ? count_q + 1'b1 : count_q;
		push_desc.overflow = overflow_q || !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			bank_q     <= '0;
		end else if (accept) begin
			if (in_data.point_last) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
				bank_q     <= bank_q + 1'b1;
			end else if (room) begin
				count_q <= count_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("vertex count ran past capacity");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> count_q == CNT_W'(MAX_POINTS))
		else $error("overflow flagged while the ring still had room");

endmodule

### rtl/pcpr_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of closed rings between the front end and the back end.
module pcpr_queue import pcpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ring_desc_t push_desc,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output ring_desc_t head
);

	ring_desc_t        slot_q [BANKS];
	logic [BANK_W-1:0] wr_ptr_q;
	logic [BANK_W-1:0] rd_ptr_q;
	logic [BANK_W:0]   fill_q;

	assign full       = fill_q == (BANK_W + 1)'(BANKS);
	assign head_valid = fill_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("ring pushed into a full queue");

endmodule

### rtl/pcpr_back.sv
`timescale 1ns / 1ps
// Back end: vertex memory, pipelined sine test per vertex and emission of the ring.
module pcpr_back import pcpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  vtx_wr_t          wr,
	input  logic [TOL_W-1:0] tol,
	input  logic             head_valid,
	input  ring_desc_t       head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          out_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_DRAIN,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	localparam int C = COORD_BITS;

	state_t state_q;

	logic [2*C-1:0] vtx_mem [MEM_DEPTH];
	logic           keep_mem [KEEP_DEPTH];
	logic [2*C-1:0] rdata_q;
	logic           keep_rd_q;
	logic           rd_en;
	logic [IDX_W-1:0] rd_idx;

	logic [SEQ_W-1:0] seq_q;
	logic [IDX_W-1:0] emit_idx_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] left_q;
	logic             unchanged_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             rvalid_q;
	logic [SEQ_W-1:0] rseq_q;
	logic [2*C-1:0]   w1_q;
	logic [2*C-1:0]   w2_q;

	logic [IDX_W-1:0] last_idx;
	logic             test_end;
	logic             sel;
	logic             out_free;
	logic             at_last;
	logic             advance;
	logic             keep_now;
	logic             ring_done;
	logic [CNT_W-1:0] kept_next;

	logic [C-1:0] px, py, cx, cy, nx, ny;
	logic signed [DIFF_W-1:0] abx_c, aby_c, bcx_c, bcy_c;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [DIFF_W-1:0] abx_s1, aby_s1, bcx_s1, bcy_s1;
	logic signed [PROD_W-1:0] mc1_s2, mc2_s2, max_s2, may_s2, mbx_s2, mby_s2;
	logic signed [PROD_W:0]   cr_c;
	logic [PROD_W-1:0]        ac_s3, l1_s3, l2_s3;
	logic [CSQ_W-1:0]         csq_s4, rhs_s4, rhs_s5, rhs_s6;
	logic [PROD_W+TOL_W-1:0]  pl_s5, ph_s5;
	logic [LHS_W-1:0]         lhs_s6;

	assign last_idx = IDX_W'(head.count - 1'b1);
	assign test_end = seq_q == SEQ_W'(head.count) + SEQ_W'(1);

	// Test pass reads the ring as last, 0, 1, ..., last, 0 so that a three-entry
	// window slides over every vertex with its cyclic neighbors.
	always_comb begin
		case (state_q)
			S_TEST: begin
				if (seq_q == '0) begin
					rd_idx = last_idx;
				end else if (test_end) begin
					rd_idx = '0;
				end else begin
					rd_idx = IDX_W'(seq_q - 1'b1);
				end
			end
			S_EMIT:  rd_idx = emit_idx_q + 1'b1;
			default: rd_idx = emit_idx_q;
		endcase
	end

	assign sel      = unchanged_q || keep_rd_q;
	assign out_free = !out_valid_q || !out_stall;
	assign at_last  = emit_idx_q == last_idx;
	assign advance  = (state_q == S_EMIT) && (!sel || out_free);
	assign pop      = advance && at_last;
	assign rd_en    = (state_q == S_TEST) || (state_q == S_EMIT_RD) || (advance && !at_last);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			vtx_mem[wr.addr] <= {wr.x, wr.y};
		end
		if (rd_en) begin
			rdata_q <= vtx_mem[{head.bank, rd_idx}];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6) begin
			keep_mem[idx_s6] <= keep_now;
		end
		if (rd_en) begin
			keep_rd_q <= keep_mem[rd_idx];
		end
	end

	// Window: w1 is the predecessor, w2 the vertex, the fresh read the successor.
	assign px = w1_q[2*C-1:C];
	assign py = w1_q[C-1:0];
	assign cx = w2_q[2*C-1:C];
	assign cy = w2_q[C-1:0];
	assign nx = rdata_q[2*C-1:C];
	assign ny = rdata_q[C-1:0];

	assign abx_c = {cx[C-1], cx} - {px[C-1], px};
	assign aby_c = {cy[C-1], cy} - {py[C-1], py};
	assign bcx_c = {nx[C-1], nx} - {cx[C-1], cx};
	assign bcy_c = {ny[C-1], ny} - {cy[C-1], cy};

	assign cr_c = {mc1_s2[PROD_W-1], mc1_s2} - {mc2_s2[PROD_W-1], mc2_s2};

	always_ff @(posedge clk) begin
		rseq_q <= seq_q;
		if (rvalid_q) begin
			w1_q <= w2_q;
			w2_q <= rdata_q;
		end

		abx_s1 <= abx_c;
		aby_s1 <= aby_c;
		bcx_s1 <= bcx_c;
		bcy_s1 <= bcy_c;
		idx_s1 <= IDX_W'(rseq_q - SEQ_W'(2));

		mc1_s2 <= abx_s1 * bcy_s1;
		mc2_s2 <= aby_s1 * bcx_s1;
		max_s2 <= abx_s1 * abx_s1;
		may_s2 <= aby_s1 * aby_s1;
		mbx_s2 <= bcx_s1 * bcx_s1;
		mby_s2 <= bcy_s1 * bcy_s1;
		idx_s2 <= idx_s1;

		ac_s3  <= cr_c[PROD_W] ? PROD_W'(-cr_c) : PROD_W'(cr_c);
		l1_s3  <= $unsigned(max_s2) + $unsigned(may_s2);
		l2_s3  <= $unsigned(mbx_s2) + $unsigned(mby_s2);
		idx_s3 <= idx_s2;

		csq_s4 <= ac_s3 * ac_s3;
		rhs_s4 <= l1_s3 * l2_s3;
		idx_s4 <= idx_s3;

		// The squared cross product is scaled in two halves to keep each product narrow.
		pl_s5  <= csq_s4[PROD_W-1:0] * tol;
		ph_s5  <= csq_s4[CSQ_W-1:PROD_W] * tol;
		rhs_s5 <= rhs_s4;
		idx_s5 <= idx_s4;

		lhs_s6 <= {ph_s5, {PROD_W{1'b0}}} + LHS_W'(pl_s5);
		rhs_s6 <= rhs_s5;
		idx_s6 <= idx_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
		end else begin
			rvalid_q <= state_q == S_TEST;
			v_s1     <= rvalid_q && (rseq_q >= SEQ_W'(2));
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
		end
	end

	assign keep_now  = lhs_s6 > LHS_W'(rhs_s6);
	assign ring_done = v_s6 && (idx_s6 == last_idx);
	assign kept_next = kept_q + CNT_W'(keep_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_q       <= '0;
			emit_idx_q  <= '0;
			kept_q      <= '0;
			left_q      <= '0;
			unchanged_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (v_s6 && keep_now) begin
				kept_q <= kept_next;
			end
			if (advance && sel) begin
				out_valid_q          <= 1'b1;
				out_q.out_x          <= rdata_q[2*C-1:C];
				out_q.out_y          <= rdata_q[C-1:0];
				out_q.out_last       <= unchanged_q ? at_last : (left_q == CNT_W'(1));
				out_q.ring_unchanged <= unchanged_q;
				out_q.overflow       <= head.overflow;
				if (!unchanged_q) begin
					left_q <= left_q - 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						emit_idx_q <= '0;
						kept_q     <= '0;
						seq_q      <= '0;
						if (head.count >= CNT_W'(MIN_RING)) begin
							unchanged_q <= 1'b0;
							state_q     <= S_TEST;
						end else begin
							unchanged_q <= 1'b1;
							state_q     <= S_EMIT_RD;
						end
					end
				end
				S_TEST: begin
					seq_q <= seq_q + 1'b1;
					if (test_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (ring_done) begin
						unchanged_q <= kept_next < CNT_W'(MIN_RING);
						left_q      <= kept_next;
						state_q     <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (advance) begin
						if (at_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pop_left: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !unchanged_q |-> left_q == CNT_W'(keep_rd_q))
		else $error("kept vertex count disagrees with the keep marks at ring end");

	a_busy_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> head_valid)
		else $error("ring descriptor lost while the ring is in work");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ring_done |-> state_q == S_DRAIN)
		else $error("last sine test finished outside the drain wait");

endmodule

### rtl/polygon_collinear_point_removal_top.sv
`timescale 1ns / 1ps
// Top level of the collinear vertex removal block.
//
// Input channel: one vertex per request (in_valid / in_stall, payload in_data);
// point_last closes a ring. Vertices beyond 64 are dropped and the ring's
// results carry overflow. Output channel: one kept vertex per request
// (out_valid / out_stall, payload out_data), out_last on the final one.
// The front end takes one vertex per cycle while in_stall is low, into one of two
// memory banks, so a ring can be loaded while the previous one is still being
// worked on; in_stall is high only while both banks hold rings.
// For a ring of n vertices (n >= 3) the back end reads the bank n + 2 times for
// the sine test, waits for the test pipeline to drain, then reads it once per
// vertex to emit. The back end works on one ring at a time through the single
// read port of the vertex memory. Rings of one or two vertices skip the test.
// A stalled result holds in the output register and emission pauses. Reset
// empties both banks and the queue and sets the tolerance register to 100000000;
// cfg_wr_en / cfg_wr_data write it; the user must write it only when idle, as the
// block itself does not enforce this.
module polygon_collinear_point_removal_top import pcpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  point_t           in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          out_data,
	input  logic             cfg_wr_en,
	input  logic [TOL_W-1:0] cfg_wr_data
);

	logic [TOL_W-1:0] tol_q;
	vtx_wr_t          wr;
	logic             push;
	ring_desc_t       push_desc;
	logic             q_full;
	logic             pop;
	logic             head_valid;
	ring_desc_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	pcpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.wr        (wr),
		.push      (push),
		.push_desc (push_desc)
	);

	pcpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	pcpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.tol        (tol_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the collinear vertex removal block.
module tb_top import pcpr_pkg::*;;

	localparam int DRAIN_CYCLES   = 160;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 65;
	localparam int PHASES         = 7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	point_t           in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	result_t          out_data;
	logic             cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;

	point_t  vertex_feed_q[$];
	result_t kept_vertex_q[$];

	// Predictor state: the ring being collected and the tolerance in force.
	logic signed [COORD_BITS-1:0] ring_x [MAX_POINTS];
	logic signed [COORD_BITS-1:0] ring_y [MAX_POINTS];
	int                           ring_n = 0;
	bit                           ring_ovf = 1'b0;
	logic [TOL_W-1:0]             tol_now = TOL_RESET;

	bit in_taken = 1'b0;
	bit calm_in = 1'b0;
	bit calm_out = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int phase_items = 0;
	int total_items = 0;
	int rings_closed = 0;
	int fallback_rings = 0;
	int overflow_rings = 0;
	int results_checked = 0;

	polygon_collinear_point_removal_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Sine test without division: cross^2 * tol > |AB|^2 * |BC|^2.
	function automatic bit vertex_survives(int i, int n);
		int          ip, inx;
		longint      ax, ay, bx, by, cr;
		logic [127:0] cross_term, len_term;
		ip  = (i + n - 1) % n;
		inx = (i + 1) % n;
		ax  = longint'(ring_x[i]) - longint'(ring_x[ip]);
		ay  = longint'(ring_y[i]) - longint'(ring_y[ip]);
		bx  = longint'(ring_x[inx]) - longint'(ring_x[i]);
		by  = longint'(ring_y[inx]) - longint'(ring_y[i]);
		cr  = ax * by - ay * bx;
		if (cr < 0)
			cr = -cr;
		cross_term = 128'(cr) * 128'(cr) * 128'(tol_now);
		len_term   = 128'(ax * ax + ay * ay) * 128'(bx * bx + by * by);
		return cross_term > len_term;
	endfunction

	task automatic emit_vertex(input int i, input bit last, input bit fallback);
		result_t r;
		r.out_x          = ring_x[i];
		r.out_y          = ring_y[i];
		r.out_last       = last;
		r.ring_unchanged = fallback;
		r.overflow       = ring_ovf;
		kept_vertex_q.push_back(r);
	endtask

	task automatic take_vertex(input point_t p);
		bit keep [MAX_POINTS];
		int kept, left, i;
		bit fallback;
		if (ring_n < MAX_POINTS) begin
			ring_x[ring_n] = p.point_x;
			ring_y[ring_n] = p.point_y;
			ring_n++;
		end else begin
			ring_ovf = 1'b1;
		end
		if (!p.point_last)
			return;
		kept = 0;
		for (i = 0; i < ring_n; i++) begin
			keep[i] = (ring_n >= MIN_RING) && vertex_survives(i, ring_n);
			kept += keep[i];
		end
		fallback = (ring_n < MIN_RING) || (kept < MIN_RING);
		left = kept;
		for (i = 0; i < ring_n; i++) begin
			if (fallback) begin
				emit_vertex(i, i == ring_n - 1, 1'b1);
			end else if (keep[i]) begin
				left--;
				emit_vertex(i, left == 0, 1'b0);
			end
		end
		rings_closed++;
		fallback_rings += fallback;
		overflow_rings += ring_ovf;
		ring_n   = 0;
		ring_ovf = 1'b0;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (kept_vertex_q.size() == 0) begin
			$error("unexpected result: out_x=%0d out_y=%0d", got.out_x, got.out_y);
			mismatches++;
			return;
		end
		want = kept_vertex_q.pop_front();
		results_checked++;
		if (got.out_x !== want.out_x) begin
			$error("out_x expected %0d got %0d", want.out_x, got.out_x);
			mismatches++;
		end
		if (got.out_y !== want.out_y) begin
			$error("out_y expected %0d got %0d", want.out_y, got.out_y);
			mismatches++;
		end
		if (got.out_last !== want.out_last) begin
			$error("out_last expected %0b got %0b", want.out_last, got.out_last);
			mismatches++;
		end
		if (got.ring_unchanged !== want.ring_unchanged) begin
			$error("ring_unchanged expected %0b got %0b", want.ring_unchanged,
				got.ring_unchanged);
			mismatches++;
		end
		if (got.overflow !== want.overflow) begin
			$error("overflow expected %0b got %0b", want.overflow, got.overflow);
			mismatches++;
		end
	endtask

	// Sampling side: accepted requests feed the predictor, results are checked.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			take_vertex(in_data);
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);
		if (in_taken || (arst_n && out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Input driver: a presented request holds until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (vertex_feed_q.size() > 0) begin
				in_data  <= vertex_feed_q.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < 3)
					calm_in = !calm_in;
				gap_left = calm_in ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, with occasional calm stretches.
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			calm_out = !calm_out;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (!calm_out && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	task automatic push_vertex(input int x, input int y, input bit last);
		point_t p;
		p.point_x    = 16'(x);
		p.point_y    = 16'(y);
		p.point_last = last;
		vertex_feed_q.push_back(p);
		phase_items++;
		total_items++;
	endtask

	function automatic int random_step();
		int r, m;
		r = $urandom_range(0, 99);
		m = (r < 40) ? 50 : (r < 80) ? 3000 : 32767;
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic int wrap_coord(input int v);
		logic signed [COORD_BITS-1:0] w;
		w = v[COORD_BITS-1:0];
		return int'(w);
	endfunction

	function automatic int pick_ring_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(1, 2);
		if (r < 78)
			return $urandom_range(3, 10);
		if (r < 92)
			return $urandom_range(11, 40);
		if (r < 97)
			return $urandom_range(60, 64);
		return $urandom_range(65, 72);
	endfunction

	// A ring is walked step by step; repeated, doubled, reversed or zero steps
	// give exactly collinear vertices, and nudged steps give near-collinear ones.
	task automatic queue_ring(input int n);
		int  k, r, x, y, dx, dy, mx, my;
		bit  scatter;
		scatter = ($urandom_range(0, 99) < 15);
		x  = int'($urandom_range(0, 65535)) - 32768;
		y  = int'($urandom_range(0, 65535)) - 32768;
		dx = random_step();
		dy = random_step();
		for (k = 0; k < n; k++) begin
			push_vertex(x, y, k == n - 1);
			if (scatter) begin
				x = int'($urandom_range(0, 65535)) - 32768;
				y = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
				end else if (r < 38) begin
					dx = wrap_coord(2 * dx);
					dy = wrap_coord(2 * dy);
				end else if (r < 58) begin
					dx += int'($urandom_range(0, 2)) - 1;
					dy += int'($urandom_range(0, 2)) - 1;
				end else begin
					dx = random_step();
					dy = random_step();
				end
				mx = dx;
				my = dy;
				r = $urandom_range(0, 99);
				if (r < 8) begin
					mx = 0;
					my = 0;
				end else if (r < 14) begin
					mx = -dx;
					my = -dy;
				end
				x = wrap_coord(x + mx);
				y = wrap_coord(y + my);
			end
		end
	endtask

	task automatic wait_idle();
		while (vertex_feed_q.size() != 0 || in_valid || kept_vertex_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		tol_now = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [TOL_W-1:0] tol_plan [PHASES];
		int               ph;
		tol_plan = '{TOL_RESET, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd5000, TOL_RESET};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rings under the reset tolerance.
		push_vertex(32767, -32768, 1'b1);
		push_vertex(-32768, 32767, 1'b0);
		push_vertex(0, 0, 1'b1);
		push_vertex(-32768, -32768, 1'b0);
		push_vertex(32767, -32768, 1'b0);
		push_vertex(0, 32767, 1'b1);
		push_vertex(0, 0, 1'b0);
		push_vertex(100, 0, 1'b0);
		push_vertex(200, 0, 1'b0);
		push_vertex(200, 200, 1'b0);
		push_vertex(0, 200, 1'b0);
		push_vertex(0, 100, 1'b1);
		// Duplicated vertices leave only two survivors, so the ring falls back.
		push_vertex(10, 10, 1'b0);
		push_vertex(10, 10, 1'b0);
		push_vertex(50, 10, 1'b0);
		push_vertex(30, 40, 1'b1);
		push_vertex(0, 0, 1'b0);
		push_vertex(0, 0, 1'b0);
		push_vertex(100, 0, 1'b0);
		push_vertex(100, 100, 1'b0);
		push_vertex(50, 150, 1'b0);
		push_vertex(0, 100, 1'b1);
		push_vertex(1, 1, 1'b0);
		push_vertex(2, 2, 1'b0);
		push_vertex(3, 3, 1'b0);
		push_vertex(5, 5, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				write_tolerance((ph == 4) ? TOL_W'($urandom) : tol_plan[ph]);
				@(posedge clk);
				phase_items = 0;
			end
			if (ph == 2)
				queue_ring(66);
			if (ph == 3)
				queue_ring(64);
			while (phase_items < PHASE_ITEMS)
				queue_ring(pick_ring_size());
		end

		wait_idle();
		$display("Sent %0d vertex requests in %0d rings under %0d tolerance settings.",
			total_items, rings_closed, PHASES);
		$display("Checked %0d results; %0d rings fell back unchanged, %0d overflowed.",
			results_checked, fallback_rings, overflow_rings);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
rtl/pcpr_pkg.sv
rtl/pcpr_front.sv
rtl/pcpr_queue.sv
rtl/pcpr_back.sv
rtl/polygon_collinear_point_removal_top.sv
test/tb_top.sv
